### src/slcc_pkg.sv
// slcc_pkg: payload types, register indexes and constants for the
// scheduled load cutoff controller. No dependencies.
package slcc_pkg;

    // input transaction: one clock tick with the latest power reading
    typedef struct packed {
        logic        clock_known;
        logic [2:0]  day_of_week;
        logic [10:0] minute_of_day;
        logic [31:0] time_ms;
        logic [15:0] power_watts;
        logic        power_ok;
    } t_in;

    // output transaction: relay drive and status
    typedef struct packed {
        logic       relay_energized;
        logic [1:0] cutoff_phase;
        logic       open_hours;
    } t_out;

    // configuration register indexes
    localparam logic [2:0] REG_OVERRIDE  = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_GRACE     = 3'd2;
    localparam logic [2:0] REG_WIN_A     = 3'd3;
    localparam logic [2:0] REG_WIN_B     = 3'd4;
    localparam logic [2:0] REG_WIN_C     = 3'd5;
    localparam logic [2:0] REG_WIN_D     = 3'd6;

    // override modes (code three behaves as automatic)
    localparam logic [1:0] MODE_AUTO      = 2'd0;
    localparam logic [1:0] MODE_FORCE_CUT = 2'd1;
    localparam logic [1:0] MODE_FORCE_ON  = 2'd2;

    // cutoff phases
    localparam logic [1:0] PH_ALLOWED = 2'd0;
    localparam logic [1:0] PH_MONITOR = 2'd1;
    localparam logic [1:0] PH_LATCHED = 2'd2;

    localparam int          NUM_WIN       = 4;
    localparam int          WIN_W         = 30;
    localparam int          GRACE_MS_W    = 27;   // 2047 * 60000 fits
    localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [2:0]  DAY_SAT       = 3'd6;

    // reset values
    localparam logic [15:0]           THRESHOLD_RST = 16'd200;
    localparam logic [10:0]           GRACE_RST     = 11'd10;
    localparam logic [GRACE_MS_W-1:0] GRACE_MS_RST  = 27'd600000;

endpackage

### src/scheduled_load_cutoff_controller.sv
// scheduled_load_cutoff_controller: top level, configuration registers,
// input register, cutoff state update and output register.
// Depends on slcc_pkg and slcc_window.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data  (slcc_pkg::t_in)
//  output  | o_out_valid | i_out_ready | o_out_data (slcc_pkg::t_out)
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the output side is ready; an
// accepted transaction passes through the input register, then the output
// register, where its result is held until it is taken.
// The state update is one shallow pass over the four window compares.
// Synchronous active-low reset clears state and returns registers to
// their defaults. A stalled output holds; the input register keeps
// accepting while the output side moves. Config is always ready.
module scheduled_load_cutoff_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  slcc_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output slcc_pkg::t_out             o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [slcc_pkg::WIN_W-1:0] i_cfg_data
);

    // configuration
    logic [1:0]                      r_mode;
    logic [15:0]                     r_threshold;
    logic [slcc_pkg::GRACE_MS_W-1:0] r_grace_ms;
    logic [slcc_pkg::WIN_W-1:0]      r_win [slcc_pkg::NUM_WIN];

    // pipeline and state
    logic           r_in_valid;
    slcc_pkg::t_in  r_in;
    logic           r_out_valid;
    slcc_pkg::t_out r_out;
    logic           r_energized, n_energized;
    logic [1:0]     r_phase, n_phase;
    logic [31:0]    r_start_ms, n_start_ms;

    logic advance;
    logic fire;
    logic [2:0] prev_day;
    logic [slcc_pkg::NUM_WIN-1:0] win_present;
    logic [slcc_pkg::NUM_WIN-1:0] win_match;
    logic configured;
    logic open_now;
    logic idle;
    logic elapsed;
    logic [31:0] since_ms;
    logic [26:0] grace_prod;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign fire        = r_in_valid && advance;

    // grace time in ms, computed on write so the tick path only compares
    assign grace_prod = 27'(i_cfg_data[10:0]) * 27'(slcc_pkg::MS_PER_MINUTE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= slcc_pkg::MODE_AUTO;
            r_threshold <= slcc_pkg::THRESHOLD_RST;
            r_grace_ms  <= slcc_pkg::GRACE_MS_RST;
            for (int k = 0; k < slcc_pkg::NUM_WIN; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slcc_pkg::REG_OVERRIDE:  r_mode      <= i_cfg_data[1:0];
                slcc_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[15:0];
                slcc_pkg::REG_GRACE:     r_grace_ms  <= grace_prod;
                slcc_pkg::REG_WIN_A:     r_win[0]    <= i_cfg_data;
                slcc_pkg::REG_WIN_B:     r_win[1]    <= i_cfg_data;
                slcc_pkg::REG_WIN_C:     r_win[2]    <= i_cfg_data;
                slcc_pkg::REG_WIN_D:     r_win[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // previous weekday; day seven wraps to Saturday as well
    assign prev_day = (r_in.day_of_week == 3'd0) ? slcc_pkg::DAY_SAT
                                                 : r_in.day_of_week - 3'd1;

    // window matchers
    for (genvar g = 0; g < slcc_pkg::NUM_WIN; g++) begin : g_win
        slcc_window u_win (
            .i_window  (r_win[g]),
            .i_dow     (r_in.day_of_week),
            .i_prev    (prev_day),
            .i_minute  (r_in.minute_of_day),
            .o_present (win_present[g]),
            .o_match   (win_match[g])
        );
    end

    assign configured = |win_present;
    assign open_now   = r_in.clock_known && (|win_match);
    assign idle       = r_in.power_ok && (r_in.power_watts < r_threshold);

    // cutoff state update for the registered tick
    always_comb begin
        n_energized = r_energized;
        n_phase     = r_phase;
        n_start_ms  = r_start_ms;
        since_ms    = r_in.time_ms - r_start_ms;
        elapsed     = 1'b0;
        case (r_mode)
            slcc_pkg::MODE_FORCE_CUT: n_energized = 1'b1;
            slcc_pkg::MODE_FORCE_ON:  n_energized = 1'b0;
            default: begin
                if (!configured || !r_in.clock_known || open_now) begin
                    n_energized = 1'b0;
                    n_phase     = slcc_pkg::PH_ALLOWED;
                end else begin
                    case (r_phase)
                        slcc_pkg::PH_ALLOWED: begin
                            // off hours just began: elapsed only with zero grace
                            n_start_ms = r_in.time_ms;
                            elapsed    = (r_grace_ms == '0);
                            if (idle || elapsed) begin
                                n_energized = 1'b1;
                                n_phase     = slcc_pkg::PH_LATCHED;
                            end else begin
                                n_phase = slcc_pkg::PH_MONITOR;
                            end
                        end
                        slcc_pkg::PH_MONITOR: begin
                            elapsed = since_ms >= 32'(r_grace_ms);
                            if (idle || elapsed) begin
                                n_energized = 1'b1;
                                n_phase     = slcc_pkg::PH_LATCHED;
                            end
                        end
                        slcc_pkg::PH_LATCHED: n_energized = 1'b1;
                        default: ;
                    endcase
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_energized <= 1'b0;
            r_phase     <= slcc_pkg::PH_ALLOWED;
            r_start_ms  <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_energized <= n_energized;
                r_phase     <= n_phase;
                r_start_ms  <= n_start_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.relay_energized <= n_energized;
            r_out.cutoff_phase    <= n_phase;
            r_out.open_hours      <= open_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/slcc_window.sv
// slcc_window: matches one open-hours window against the current tick,
// including the overnight tail of a window that began the day before.
// Depends on slcc_pkg.
module slcc_window (
    input  logic [slcc_pkg::WIN_W-1:0] i_window,
    input  logic [2:0]                 i_dow,
    input  logic [2:0]                 i_prev,
    input  logic [10:0]                i_minute,
    output logic                       o_present,
    output logic                       o_match
);

    logic [6:0]  mask;
    logic [10:0] on_min;
    logic [10:0] off_min;
    logic        today;
    logic        yday;
    logic        usable;

    // field split
    assign o_present = i_window[29];
    assign mask      = i_window[28:22];
    assign on_min    = i_window[21:11];
    assign off_min   = i_window[10:0];

    // day value seven selects no weekday bit
    assign today  = (i_dow != 3'd7) && mask[i_dow];
    assign yday   = mask[i_prev];
    assign usable = o_present && (on_min < slcc_pkg::MIN_PER_DAY)
                    && (off_min < slcc_pkg::MIN_PER_DAY) && (on_min != off_min);

    // same-day span, or evening part plus next-morning tail
    always_comb begin
        if (!usable) begin
            o_match = 1'b0;
        end else if (on_min < off_min) begin
            o_match = today && (i_minute >= on_min) && (i_minute < off_min);
        end else begin
            o_match = (today && (i_minute >= on_min)) || (yday && (i_minute < off_min));
        end
    end

endmodule

### src/slcc_checker.sv
// slcc_assertions: port-level assertions for the cutoff controller, bound
// to the top level. Depends on slcc_pkg and scheduled_load_cutoff_controller.
module slcc_assertions (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input slcc_pkg::t_out o_out_data
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    // with an empty output stage the input side never stalls
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // phase code three is never produced
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.cutoff_phase != 2'd3)
        else $error("bad cutoff phase");

endmodule

bind scheduled_load_cutoff_controller slcc_assertions u_slcc_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### test/slcc_checker.sv
`timescale 1ns / 100ps
// slcc_checker: watches the input, output and register channels of the
// scheduled load cutoff controller, predicts each result and compares it.
// Depends on slcc_pkg for payload types, register indexes and codes.
module slcc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  slcc_pkg::t_in              i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  slcc_pkg::t_out             i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [slcc_pkg::WIN_W-1:0] i_cfg_data,
    input  logic                       i_wrap_up,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_cut_count
);
    import slcc_pkg::*;

    localparam int REPORT_LINES = 40;

    // register copies
    logic [1:0]       mode_q;
    logic [15:0]      thr_q;
    logic [10:0]      grace_q;
    logic [WIN_W-1:0] win_q [NUM_WIN];

    // cutoff state
    logic        relay_q;
    logic [1:0]  phase_q;
    logic [31:0] start_ms_q;

    t_out expected_q[$];
    int   fails   = 0;
    int   checked = 0;
    int   cuts    = 0;
    bit   wrapped = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_cut_count  = 0;
    end

    task automatic report(input string msg);
        if (fails < REPORT_LINES)
            $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    // one window against the tick; evening part may spill into the next day
    function automatic logic window_hit(input logic [WIN_W-1:0] w, input logic [2:0] dow,
                                        input logic [10:0] minute);
        logic [6:0]  mask;
        logic [10:0] on_min;
        logic [10:0] off_min;
        logic [2:0]  prev;
        logic        today;
        logic        yday;
        mask    = w[28:22];
        on_min  = w[21:11];
        off_min = w[10:0];
        prev    = (dow == 3'd0) ? DAY_SAT : dow - 3'd1;
        today   = (dow <= DAY_SAT) && mask[dow];
        yday    = mask[prev];
        if (!w[29] || on_min >= MIN_PER_DAY || off_min >= MIN_PER_DAY || on_min == off_min)
            return 1'b0;
        if (on_min < off_min)
            return today && minute >= on_min && minute < off_min;
        return (today && minute >= on_min) || (yday && minute < off_min);
    endfunction

    // advance the cutoff state by one tick and form the expected result
    task automatic advance_cutoff(input t_in tk, output t_out res);
        logic        configured;
        logic        open_now;
        logic        idle;
        logic        elapsed;
        logic [31:0] since;
        int          i;
        configured = 1'b0;
        open_now   = 1'b0;
        for (i = 0; i < NUM_WIN; i++) begin
            if (win_q[i][29])
                configured = 1'b1;
            if (window_hit(win_q[i], tk.day_of_week, tk.minute_of_day))
                open_now = 1'b1;
        end
        if (!tk.clock_known)
            open_now = 1'b0;

        case (mode_q)
            MODE_FORCE_CUT: relay_q = 1'b1;
            MODE_FORCE_ON:  relay_q = 1'b0;
            default: begin
                if (!configured || !tk.clock_known || open_now) begin
                    relay_q = 1'b0;
                    phase_q = PH_ALLOWED;
                end else begin
                    // off hours just began: remember when
                    if (phase_q == PH_ALLOWED) begin
                        start_ms_q = tk.time_ms;
                        phase_q    = PH_MONITOR;
                    end
                    if (phase_q == PH_MONITOR) begin
                        idle    = tk.power_ok && (tk.power_watts < thr_q);
                        since   = tk.time_ms - start_ms_q;
                        elapsed = since >= (32'(grace_q) * 32'(MS_PER_MINUTE));
                        if (idle || elapsed) begin
                            relay_q = 1'b1;
                            phase_q = PH_LATCHED;
                        end
                    end else if (phase_q == PH_LATCHED) begin
                        relay_q = 1'b1;
                    end
                end
            end
        endcase

        res.relay_energized = relay_q;
        res.cutoff_phase    = phase_q;
        res.open_hours      = open_now;
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            mode_q     = MODE_AUTO;
            thr_q      = THRESHOLD_RST;
            grace_q    = GRACE_RST;
            win_q[0]   = '0;
            win_q[1]   = '0;
            win_q[2]   = '0;
            win_q[3]   = '0;
            relay_q    = 1'b0;
            phase_q    = PH_ALLOWED;
            start_ms_q = '0;
            expected_q.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OVERRIDE:  mode_q   = i_cfg_data[1:0];
                    REG_THRESHOLD: thr_q    = i_cfg_data[15:0];
                    REG_GRACE:     grace_q  = i_cfg_data[10:0];
                    REG_WIN_A:     win_q[0] = i_cfg_data;
                    REG_WIN_B:     win_q[1] = i_cfg_data;
                    REG_WIN_C:     win_q[2] = i_cfg_data;
                    REG_WIN_D:     win_q[3] = i_cfg_data;
                    default: ;
                endcase
            end

            // tick accepted: predict its result
            if (i_in_valid && i_in_ready) begin
                advance_cutoff(i_in_data, want);
                expected_q.push_back(want);
                if (want.cutoff_phase == PH_LATCHED)
                    cuts++;
            end

            // result accepted: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("result transaction with no tick outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_data.relay_energized !== want.relay_energized)
                        report($sformatf("result %0d relay_energized %b, expected %b", checked,
                                         i_out_data.relay_energized, want.relay_energized));
                    if (i_out_data.cutoff_phase !== want.cutoff_phase)
                        report($sformatf("result %0d cutoff_phase %0d, expected %0d", checked,
                                         i_out_data.cutoff_phase, want.cutoff_phase));
                    if (i_out_data.open_hours !== want.open_hours)
                        report($sformatf("result %0d open_hours %b, expected %b", checked,
                                         i_out_data.open_hours, want.open_hours));
                    checked++;
                end
            end

            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_q.size() != 0)
                    report($sformatf("%0d results never arrived", expected_q.size()));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_cut_count  <= cuts;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// testbench: clock, reset, tick and register stimulus for the scheduled load
// cutoff controller. Depends on slcc_pkg, the block and slcc_checker.
module testbench;
    import slcc_pkg::*;

    localparam logic [1:0] MODE_SPARE     = 2'd3;  // unused code, acts as automatic
    localparam int         NUM_PHASES     = 10;
    localparam int         PHASE_TICKS    = 153;
    localparam int         CALM_TICKS     = 150;
    localparam int         NOISE_PCT      = 12;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = REG_OVERRIDE;
    logic [WIN_W-1:0] cfg_data  = '0;
    logic             wrap_up   = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int cuts;

    // stimulus knobs
    bit          calm       = 1'b0;
    int          gap_odds   = 2;
    int          stall_odds = 2;
    logic [15:0] cur_thr    = THRESHOLD_RST;
    int          ticks_sent = 0;
    int          settings   = 0;
    int          quiet_cycles = 0;

    // wall clock of the well-formed tick stream
    int          sim_day = 0;
    int          sim_min = 0;
    logic [31:0] sim_ms  = '0;

    scheduled_load_cutoff_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    slcc_checker cutoff_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_wrap_up    (wrap_up),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_cut_count  (cuts)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog: cycles without any accepted transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("scheduled_load_cutoff_controller test failed");
        $finish;
    end

    // result side backpressure in random bursts
    initial begin : out_pacing
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 15) < stall_odds) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [WIN_W-1:0] win(input logic present, input logic [6:0] mask,
                                             input logic [10:0] on_min,
                                             input logic [10:0] off_min);
        return {present, mask, on_min, off_min};
    endfunction

    // one tick transaction, with an optional idle burst ahead of it
    task automatic send_tick(input t_in d);
        if (!calm && $urandom_range(0, 15) < gap_odds) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic tick(input logic known, input logic [2:0] day, input logic [10:0] minute,
                        input logic [31:0] ms, input logic [15:0] pw, input logic ok);
        t_in t;
        t.clock_known   = known;
        t.day_of_week   = day;
        t.minute_of_day = minute;
        t.time_ms       = ms;
        t.power_watts   = pw;
        t.power_ok      = ok;
        send_tick(t);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [WIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // full register setting, written only once the block is idle
    task automatic apply_setting(input logic [1:0] mode, input logic [15:0] thr,
                                 input logic [10:0] grace, input logic [WIN_W-1:0] wa,
                                 input logic [WIN_W-1:0] wb, input logic [WIN_W-1:0] wc,
                                 input logic [WIN_W-1:0] wd);
        drain();
        write_reg(REG_OVERRIDE, WIN_W'(mode));
        write_reg(REG_THRESHOLD, WIN_W'(thr));
        write_reg(REG_GRACE, WIN_W'(grace));
        write_reg(REG_WIN_A, wa);
        write_reg(REG_WIN_B, wb);
        write_reg(REG_WIN_C, wc);
        write_reg(REG_WIN_D, wd);
        cfg_valid <= 1'b0;
        cur_thr = thr;
        settings++;
    endtask

    // random setting for one phase; some phases pin the extremes
    task automatic random_setting(input int k);
        logic [1:0]       mode;
        logic [15:0]      thr;
        logic [10:0]      grace;
        logic [WIN_W-1:0] w [NUM_WIN];
        logic [10:0]      on_min;
        int               i;
        int               r;
        mode  = MODE_AUTO;
        thr   = 16'($urandom_range(50, 2000));
        grace = 11'($urandom_range(0, 30));
        if (k == 3)
            mode = MODE_FORCE_CUT;
        else if (k == 6)
            mode = MODE_FORCE_ON;
        else if (k == 8)
            mode = MODE_SPARE;
        case (k)
            0: begin
                thr   = 16'hFFFF;
                grace = 11'd0;
            end
            1: begin
                thr   = 16'd1;
                grace = 11'd1440;
            end
            2: thr = 16'd0;
            NUM_PHASES - 1: grace = 11'h7FF;
            default: ;
        endcase
        for (i = 0; i < NUM_WIN; i++) begin
            r      = $urandom_range(0, 9);
            on_min = 11'($urandom_range(0, 1439));
            if (k == 4)
                w[i] = {1'b0, 29'($urandom())};  // unconfigured, junk in the other bits
            else if (r == 0)
                w[i] = '0;
            else if (r == 1)
                w[i] = WIN_W'($urandom());
            else if (r == 2)
                w[i] = win(1'b1, 7'($urandom()), on_min, on_min);
            else
                w[i] = win(1'b1, 7'($urandom()), on_min, 11'($urandom_range(0, 1439)));
        end
        gap_odds   = $urandom_range(0, 4);
        stall_odds = $urandom_range(0, 4);
        apply_setting(mode, thr, grace, w[0], w[1], w[2], w[3]);
    endtask

    // mostly a wall clock moving forward with random power, some raw noise
    task automatic next_random_tick(output t_in t);
        int step;
        if ($urandom_range(0, 99) < NOISE_PCT) begin
            t.clock_known   = 1'($urandom());
            t.day_of_week   = 3'($urandom());
            t.minute_of_day = 11'($urandom());
            t.time_ms       = $urandom();
            t.power_watts   = 16'($urandom());
            t.power_ok      = 1'($urandom());
        end else begin
            step = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 600) : $urandom_range(0, 3);
            sim_min += step;
            while (sim_min >= 1440) begin
                sim_min -= 1440;
                sim_day = (sim_day + 1) % 7;
            end
            sim_ms = sim_ms + 32'(step * 60000) + 32'($urandom_range(0, 59999));
            t.clock_known   = ($urandom_range(0, 29) != 0);
            t.day_of_week   = 3'(sim_day);
            t.minute_of_day = 11'(sim_min);
            t.time_ms       = sim_ms;
            if ($urandom_range(0, 7) == 0)
                t.power_watts = (cur_thr == 16'd0) ? 16'd0 : 16'($urandom_range(0, cur_thr - 1));
            else
                t.power_watts = 16'($urandom_range(cur_thr, 16'hFFFF));
            t.power_ok      = ($urandom_range(0, 4) != 0);
        end
    endtask

    initial begin : stimulus
        t_in              t;
        logic [WIN_W-1:0] wa;
        logic [WIN_W-1:0] wb;
        logic [WIN_W-1:0] wc;
        logic [WIN_W-1:0] wd;
        int               k;
        int               i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: no window configured, load stays powered
        tick(1'b1, 3'd1, 11'd600, 32'd0, 16'd500, 1'b1);
        tick(1'b0, 3'd2, 11'd1200, 32'd1000, 16'd50, 1'b1);

        // weekday daytime window, Saturday overnight window, two invalid ones
        wa = win(1'b1, 7'b0111110, 11'd480, 11'd1020);
        wb = win(1'b1, 7'b1000000, 11'd1320, 11'd120);
        wc = win(1'b1, 7'b1111111, 11'd700, 11'd700);
        wd = win(1'b1, 7'b1111111, 11'd1500, 11'd100);
        apply_setting(MODE_AUTO, 16'd200, 11'd10, wa, wb, wc, wd);
        tick(1'b1, 3'd1, 11'd600, 32'd1000, 16'd500, 1'b1);       // open hours
        tick(1'b0, 3'd1, 11'd600, 32'd2000, 16'd500, 1'b1);       // clock unknown
        tick(1'b1, 3'd1, 11'd1100, 32'd100000, 16'd500, 1'b1);    // monitoring starts
        tick(1'b1, 3'd1, 11'd1101, 32'd160000, 16'd500, 1'b1);
        tick(1'b1, 3'd1, 11'd1102, 32'd220000, 16'd100, 1'b0);    // low but stale reading
        tick(1'b1, 3'd1, 11'd1103, 32'd280000, 16'd100, 1'b1);    // idle: cut
        tick(1'b1, 3'd1, 11'd1104, 32'd340000, 16'd500, 1'b1);    // latch holds
        tick(1'b1, 3'd2, 11'd500, 32'd400000, 16'd500, 1'b1);     // open again
        tick(1'b1, 3'd0, 11'd60, 32'd500000, 16'd500, 1'b1);      // Saturday tail on Sunday
        tick(1'b1, 3'd6, 11'd1400, 32'd600000, 16'd500, 1'b1);
        tick(1'b1, 3'd7, 11'd60, 32'd700000, 16'd500, 1'b1);      // day seven, tail only
        tick(1'b1, 3'd7, 11'd1400, 32'd1000000, 16'd500, 1'b1);
        tick(1'b1, 3'd7, 11'd1401, 32'd1599999, 16'd500, 1'b1);   // one ms short of grace
        tick(1'b1, 3'd7, 11'd1402, 32'd1600000, 16'd500, 1'b1);   // grace reached
        tick(1'b1, 3'd6, 11'd2000, 32'd1700000, 16'd500, 1'b1);   // minute out of range
        tick(1'b1, 3'd3, 11'd1200, 32'd3000000, 16'd500, 1'b1);   // monitoring again

        // forced modes keep phase and start time
        apply_setting(MODE_FORCE_CUT, 16'd200, 11'd10, wa, wb, wc, wd);
        tick(1'b1, 3'd1, 11'd600, 32'd3100000, 16'd500, 1'b1);
        apply_setting(MODE_FORCE_ON, 16'd200, 11'd10, wa, wb, wc, wd);
        tick(1'b1, 3'd3, 11'd1200, 32'd3200000, 16'd500, 1'b1);

        // spare code as automatic, threshold zero, full-day grace across a wrap
        apply_setting(MODE_SPARE, 16'd0, 11'd1440, wa, wb, wc, wd);
        tick(1'b1, 3'd1, 11'd600, 32'd3300000, 16'd0, 1'b1);
        tick(1'b1, 3'd1, 11'd1100, 32'hFFFF_FC18, 16'd0, 1'b1);
        tick(1'b1, 3'd1, 11'd1101, 32'd5000, 16'd0, 1'b1);
        tick(1'b1, 3'd1, 11'd1102, 32'd86399000, 16'd0, 1'b1);

        // random phases
        sim_ms = $urandom();
        for (k = 0; k < NUM_PHASES; k++) begin
            random_setting(k);
            for (i = 0; i < PHASE_TICKS; i++) begin
                if (k == NUM_PHASES - 1 && i == PHASE_TICKS - CALM_TICKS)
                    calm = 1'b1;
                next_random_tick(t);
                send_tick(t);
            end
        end

        drain();
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d ticks under %0d register settings: all override codes, threshold",
                 ticks_sent, settings);
        $display("and grace extremes, overnight windows; %0d results compared, %0d with a cut.",
                 checked, cuts);
        if (fail_count == 0)
            $display("scheduled_load_cutoff_controller test passed");
        else
            $display("scheduled_load_cutoff_controller test failed");
        $finish;
    end

endmodule
